### hw/rtl/bpa_pkg.sv
// shared types, constants and codes of the bitmap page allocator
package bpa_pkg;

	localparam int MAX_BLOCKS = 65536;
	localparam int PG_W = $clog2(MAX_BLOCKS) + 1;     // page count, holds MAX_BLOCKS
	localparam int PI_W = $clog2(MAX_BLOCKS);         // page index
	localparam int BYTES = MAX_BLOCKS / 8;            // bitmap bytes
	localparam int BI_W = $clog2(BYTES);              // bitmap byte index
	localparam int ADDR_W = 32;
	localparam int BADDR_W = 28;
	localparam int MODE_W = 3;
	localparam int FIRST_W = ADDR_W - 12 + 1;         // page number of a rounded-up address
	localparam int END_W = FIRST_W + 1;

	localparam logic [MODE_W-1:0] MODE_RELEASE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RESERVE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ALLOC_ONE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ALLOC_RUN = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FREE_RUN  = 3'd4;

	typedef enum logic [3:0] {
		ST_FILL,
		ST_IDLE,
		ST_SETUP1,
		ST_SETUP2,
		ST_SETUP3,
		ST_COUNT,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_SEARCH,
		ST_FIN
	} bpa_state_t;

	typedef struct packed {
		logic accept;
		logic fill_init;
		logic fill_step;
		logic setup1;
		logic setup2;
		logic setup3;
		logic count_upd;
		logic mark_wr;
		logic remark_load;
		logic search_init;
		logic search_step;
		logic hit_load;
		logic set_fail;
		logic finish;
	} bpa_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic alloc_ok;
		logic is_region;
		logic is_alloc;
		logic is_release;
		logic empty;
		logic mark_last;
		logic total_nz;
		logic remark_done;
		logic hit;
		logic miss;
		logic out_busy;
	} bpa_sts_t;

endpackage

### hw/rtl/bitmap_page_allocator.sv
// top level of the first-fit bitmap page allocator
//
// channel   direction  handshake              payload
// request   in         in_valid / in_ready    mode, address, byte_size, count
// result    out        out_valid / out_ready  status, block_address, free_blocks
// config    in         cfg_valid / cfg_ready  total_blocks
//
// the bitmap is a single-port memory of MAX_BLOCKS/8 bytes, one bit per page
// region modes set up, then read and write each byte touched; a release re-marks page 0
// allocation scans one byte a cycle from page 0 up, then reads and rewrites the run's bytes
// after reset and after every config write a fill pass over all MAX_BLOCKS/8 bytes
// (8192) marks all pages used; no request is taken meanwhile
// a finished result waits in the output register while the next request is taken
module bitmap_page_allocator
	import bpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MODE_W-1:0]    mode,
	input  logic [ADDR_W-1:0]    address,
	input  logic [ADDR_W-1:0]    byte_size,
	input  logic [PG_W-1:0]      count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 status,
	output logic [BADDR_W-1:0]   block_address,
	output logic [PG_W-1:0]      free_blocks,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [PG_W-1:0]      total_blocks
);

	bpa_cmd_t cmd;
	bpa_sts_t sts;

	// register writes are always taken; they restart the fill pass
	assign cfg_ready = 1'b1;

	// sequencing of setup, counter update, marking and search
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// bitmap, used-page counter and result register
	bpa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.total_blocks  (total_blocks),
		.mode          (mode),
		.address       (address),
		.byte_size     (byte_size),
		.count         (count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.block_address (block_address),
		.free_blocks   (free_blocks)
	);

	// a failed allocation never reports an address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> block_address == '0)
		else $error("failed request carries an address");

	// a taken request keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	// search hit and miss never come together
	a_hit_miss: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.hit && sts.miss))
		else $error("search reports hit and miss at once");

	// only one bitmap operation is commanded in a cycle
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mark_wr, cmd.search_step, cmd.hit_load, cmd.setup3}))
		else $error("conflicting datapath commands");

endmodule

### hw/rtl/bpa_ctrl.sv
// controller state machine of the bitmap page allocator
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     cfg_valid,
	input  bpa_sts_t sts,
	output bpa_cmd_t cmd
);

	bpa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// after marking, or when its region is empty, a release re-marks page 0 once
	function automatic logic need_remark(bpa_sts_t s);
		return s.is_release && !s.remark_done && s.total_nz;
	endfunction

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = (state_q == ST_IDLE) && !cfg_valid;
		case (state_q)
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.accept = 1'b1;
					state_d = ST_SETUP1;
				end
			end
			ST_SETUP1: begin
				cmd.setup1 = 1'b1;
				if (sts.is_region) begin
					state_d = ST_SETUP2;
				end else if (sts.is_alloc) begin
					if (sts.alloc_ok) begin
						cmd.search_init = 1'b1;
						state_d = ST_SEARCH;
					end else begin
						cmd.set_fail = 1'b1;
						state_d = ST_FIN;
					end
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SETUP2: begin
				cmd.setup2 = 1'b1;
				state_d = ST_SETUP3;
			end
			ST_SETUP3: begin
				cmd.setup3 = 1'b1;
				state_d = ST_COUNT;
			end
			ST_COUNT: begin
				cmd.count_upd = 1'b1;
				if (!sts.empty) begin
					state_d = ST_MARK_RD;
				end else if (need_remark(sts)) begin
					cmd.remark_load = 1'b1;
					state_d = ST_MARK_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_MARK_RD: begin
				state_d = ST_MARK_WR;
			end
			ST_MARK_WR: begin
				cmd.mark_wr = 1'b1;
				if (!sts.mark_last) begin
					state_d = ST_MARK_RD;
				end else if (need_remark(sts)) begin
					cmd.remark_load = 1'b1;
					state_d = ST_MARK_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SEARCH: begin
				if (sts.hit) begin
					cmd.hit_load = 1'b1;
					state_d = ST_MARK_RD;
				end else if (sts.miss) begin
					cmd.set_fail = 1'b1;
					state_d = ST_FIN;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// a register write restarts the all-used fill
		if (cfg_valid) begin
			cmd.fill_init = 1'b1;
			cmd.fill_step = 1'b0;
			state_d = ST_FILL;
		end
	end

endmodule

### hw/rtl/bpa_dp.sv
// datapath of the bitmap page allocator: bitmap memory, counter, search and marking
module bpa_dp
	import bpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  bpa_cmd_t             cmd,
	output bpa_sts_t             sts,
	input  logic                 cfg_valid,
	input  logic [PG_W-1:0]      total_blocks,
	input  logic [MODE_W-1:0]    mode,
	input  logic [ADDR_W-1:0]    address,
	input  logic [ADDR_W-1:0]    byte_size,
	input  logic [PG_W-1:0]      count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 status,
	output logic [BADDR_W-1:0]   block_address,
	output logic [PG_W-1:0]      free_blocks
);

	logic [7:0]          mem_q [BYTES];
	logic [7:0]          rdata_s1;
	logic                rd_vld_s1;
	logic [BI_W-1:0]     rd_idx_s1;

	logic [PG_W-1:0]     total_q, used_q;
	logic [MODE_W-1:0]   mode_q;
	logic [ADDR_W-1:0]   addr_q, size_q;
	logic [PG_W-1:0]     count_q;
	logic [FIRST_W-1:0]  first_q, len_q;
	logic [END_W-1:0]    end_q;
	logic [PG_W-1:0]     lo_q, hi_q, n_q;
	logic                val_q, empty_q, remark_q, fail_q, iss_q;
	logic [BI_W-1:0]     ptr_q, last_q;
	logic [PG_W-1:0]     run_q;
	logic [PI_W-1:0]     res_q;
	logic                out_valid_q, status_q;
	logic [BADDR_W-1:0]  baddr_q;
	logic [PG_W-1:0]     free_q;

	logic [PG_W-1:0]     free_c, hi_c, n_c, run_c, pos_c, start_c, cfg_tot_c, tmp_c;
	logic                empty_c, hit_c;
	logic [7:0]          merged_c;
	logic                we_c;
	logic [7:0]          wd_c;

	// byte holding the last page below an exclusive page bound
	function automatic logic [BI_W-1:0] tmp_last(logic [PG_W-1:0] bound);
		logic [PG_W-1:0] m;
		m = bound - 1'b1;
		return m[PI_W-1:3];
	endfunction

	always_comb begin
		free_c = total_q - used_q;
		cfg_tot_c = (total_blocks > PG_W'(MAX_BLOCKS)) ? PG_W'(MAX_BLOCKS) : total_blocks;
		// clip the region to the managed pages
		hi_c = (end_q > END_W'(total_q)) ? total_q : end_q[PG_W-1:0];
		empty_c = END_W'(first_q) >= END_W'(hi_c);
		n_c = empty_c ? '0 : (hi_c - first_q[PG_W-1:0]);
		// merge one bitmap byte with the region mask
		for (int i = 0; i < 8; i++) begin
			tmp_c = PG_W'({ptr_q, 3'(i)});
			merged_c[i] = (tmp_c >= lo_q && tmp_c < hi_q) ? val_q : rdata_s1[i];
		end
		// first-fit run tracking over one byte
		run_c = run_q;
		hit_c = 1'b0;
		pos_c = '0;
		for (int i = 0; i < 8; i++) begin
			tmp_c = PG_W'({rd_idx_s1, 3'(i)});
			if (rdata_s1[i] || tmp_c == '0 || tmp_c >= total_q) begin
				run_c = '0;
			end else begin
				run_c = run_c + 1'b1;
				if (!hit_c && run_c == count_q) begin
					hit_c = 1'b1;
					pos_c = tmp_c;
				end
			end
		end
		start_c = pos_c + 1'b1 - count_q;
		we_c = cmd.fill_step || cmd.mark_wr;
		wd_c = cmd.fill_step ? 8'hFF : merged_c;
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem_q[ptr_q] <= wd_c;
		end
		rdata_s1 <= mem_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= PG_W'(MAX_BLOCKS);
			used_q <= PG_W'(MAX_BLOCKS);
			ptr_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			iss_q <= 1'b0;
			out_valid_q <= 1'b0;
			remark_q <= 1'b0;
			fail_q <= 1'b0;
			empty_q <= 1'b0;
			run_q <= '0;
			mode_q <= '0;
			addr_q <= '0;
			size_q <= '0;
			count_q <= '0;
			first_q <= '0;
			len_q <= '0;
			end_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			n_q <= '0;
			val_q <= 1'b0;
			last_q <= '0;
			res_q <= '0;
			status_q <= 1'b0;
			baddr_q <= '0;
			free_q <= '0;
		end else begin
			rd_vld_s1 <= cmd.search_step && iss_q;
			rd_idx_s1 <= ptr_q;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				total_q <= cfg_tot_c;
				used_q <= cfg_tot_c;
			end
			// bitmap byte pointer
			if (cmd.fill_init || cmd.search_init || cmd.remark_load) begin
				ptr_q <= '0;
			end else if (cmd.setup3) begin
				ptr_q <= first_q[PI_W-1:3];
			end else if (cmd.hit_load) begin
				ptr_q <= start_c[PI_W-1:3];
			end else if (cmd.fill_step || cmd.mark_wr || (cmd.search_step && iss_q)) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.accept) begin
				mode_q <= mode;
				addr_q <= address;
				size_q <= byte_size;
				count_q <= (mode == MODE_ALLOC_ONE) ? PG_W'(1) : count;
				remark_q <= 1'b0;
				fail_q <= 1'b0;
				res_q <= '0;
			end
			if (cmd.setup1) begin
				if (mode_q == MODE_RELEASE) begin
					first_q <= FIRST_W'((33'(addr_q) + 33'h0FFF) >> 12);
				end else begin
					first_q <= FIRST_W'(addr_q >> 12);
				end
				if (mode_q == MODE_FREE_RUN) begin
					len_q <= FIRST_W'(count_q);
				end else begin
					len_q <= FIRST_W'((33'(size_q) + 33'h0FFF) >> 12);
				end
			end
			if (cmd.setup2) begin
				end_q <= END_W'(first_q) + END_W'(len_q);
			end
			if (cmd.setup3) begin
				lo_q <= first_q[PG_W-1:0];
				hi_q <= hi_c;
				n_q <= n_c;
				empty_q <= empty_c;
				val_q <= (mode_q == MODE_RESERVE);
				last_q <= tmp_last(hi_c);
			end
			if (cmd.count_upd) begin
				if (mode_q == MODE_RESERVE) begin
					used_q <= used_q + ((n_q > free_c) ? free_c : n_q);
				end else begin
					used_q <= used_q - ((n_q > used_q) ? used_q : n_q);
				end
			end
			if (cmd.remark_load) begin
				remark_q <= 1'b1;
				lo_q <= '0;
				hi_q <= PG_W'(1);
				val_q <= 1'b1;
				last_q <= '0;
			end
			if (cmd.search_init) begin
				run_q <= '0;
				iss_q <= 1'b1;
				last_q <= tmp_last(total_q);
			end
			if (cmd.search_step) begin
				if (iss_q && ptr_q == last_q) begin
					iss_q <= 1'b0;
				end
				if (rd_vld_s1) begin
					run_q <= run_c;
				end
			end
			if (cmd.hit_load) begin
				iss_q <= 1'b0;
				lo_q <= start_c;
				hi_q <= pos_c + 1'b1;
				val_q <= 1'b1;
				last_q <= pos_c[PI_W-1:3];
				used_q <= used_q + count_q;
				res_q <= start_c[PI_W-1:0];
			end
			if (cmd.set_fail) begin
				fail_q <= 1'b1;
			end
			if (cmd.finish) begin
				status_q <= fail_q;
				baddr_q <= BADDR_W'({res_q, 12'h000});
				free_q <= free_c;
			end
		end
	end

	always_comb begin
		sts.fill_last = (ptr_q == BI_W'(BYTES - 1));
		sts.alloc_ok = (count_q != '0) && (count_q <= free_c);
		sts.is_region = (mode_q == MODE_RELEASE) || (mode_q == MODE_RESERVE)
			|| (mode_q == MODE_FREE_RUN);
		sts.is_alloc = (mode_q == MODE_ALLOC_ONE) || (mode_q == MODE_ALLOC_RUN);
		sts.is_release = (mode_q == MODE_RELEASE);
		sts.empty = empty_q;
		sts.mark_last = (ptr_q == last_q);
		sts.total_nz = (total_q != '0);
		sts.remark_done = remark_q;
		sts.hit = rd_vld_s1 && hit_c;
		sts.miss = rd_vld_s1 && !hit_c && (rd_idx_s1 == last_q);
		sts.out_busy = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign block_address = baddr_q;
	assign free_blocks = free_q;

endmodule
